// File: src/gccs_pkg.sv
// Shared types and constants for the graph canonical code search core.
// Holds the controller state type and the command and status bundles.
// No dependencies.
package gccs_pkg;

    localparam int CODE_W   = 36;
    localparam int COUNT_W  = 19;
    localparam int CFG_W    = 4;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 4'd9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SORT,
        ST_SEARCH,
        ST_DRAIN,
        ST_PACK,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_init;
        logic load_step;
        logic sort_init;
        logic sort_step;
        logic search_init;
        logic search_step;
        logic pack_init;
        logic pack_step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pair_none;
        logic pair_last;
        logic sort_last;
        logic perm_last;
    } stat_t;

endpackage

// File: src/gccs_ctrl.sv
// Controller state machine for the graph canonical code search core.
// Sequences load, sort, search, drain and pack phases; depends on gccs_pkg.
module gccs_ctrl
    import gccs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy,
    output logic  done
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_init = 1'b1;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (stat.pair_none)
                begin
                    cmd.sort_init = 1'b1;
                    state_next    = ST_SORT;
                end
                else
                begin
                    cmd.load_step = 1'b1;
                    if (stat.pair_last)
                    begin
                        cmd.sort_init = 1'b1;
                        state_next    = ST_SORT;
                    end
                end
            end
            ST_SORT:
            begin
                cmd.sort_step = 1'b1;
                if (stat.sort_last)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (stat.perm_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.pack_init = 1'b1;
                state_next    = ST_PACK;
            end
            ST_PACK:
            begin
                if (stat.pair_none)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.pack_step = 1'b1;
                    if (stat.pair_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

`ifndef NO_ASSERTIONS
    // A result word only appears while an item is in flight.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result strobe outside busy");
    // An accepted item makes the core busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start not taken");
    // One result word per item.
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("repeated result strobe");
`endif

endmodule

// File: src/gccs_datapath.sv
// Datapath for the graph canonical code search core: adjacency, degree sort,
// in-group permutation stepper, re-encoder and min/match tracking.
// Depends on gccs_pkg.
module gccs_datapath
    import gccs_pkg::*;
#(
    parameter int MAXV = 9
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic [CODE_W-1:0]  graph_code,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic [CODE_W-1:0]  canonical_code,
    output logic [COUNT_W-1:0] match_count
);

    localparam int V_W   = $clog2(MAXV);
    localparam int N_W   = $clog2(MAXV + 1);
    localparam int PAIRS = MAXV * (MAXV - 1) / 2;
    localparam int Q_W   = $clog2(PAIRS + 1);

    // Fixed-layout position of pair i<j for MAXV vertices.
    function automatic int pair_idx(input int i, input int j);
        return i * MAXV - (i * (i + 1)) / 2 + j - i - 1;
    endfunction

    logic [CFG_W-1:0]   cfg_reg;
    logic [N_W-1:0]     n;
    logic [Q_W-1:0]     npairs;
    logic [CODE_W-1:0]  code_reg;
    logic [PAIRS-1:0]   code_fx_reg;
    logic               high_reg;
    logic [MAXV-1:0]    adj_reg [MAXV];
    logic [V_W-1:0]     deg_reg [MAXV];
    logic [V_W-1:0]     pi_reg;
    logic [V_W-1:0]     pj_reg;
    logic [Q_W-1:0]     q_reg;
    logic [V_W-1:0]     sd_reg;
    logic [V_W-1:0]     sv_reg;
    logic [V_W-1:0]     sp_reg;
    logic [V_W-1:0]     slast_reg;
    logic [V_W-1:0]     cur_reg  [MAXV];
    logic [V_W-1:0]     base_reg [MAXV];
    logic [V_W-1:0]     cur_next [MAXV];
    logic [MAXV-1:0]    same_reg;
    logic [MAXV-1:0]    asc;
    logic [PAIRS-1:0]   x_next;
    logic [PAIRS-1:0]   x_reg;
    logic               xv_reg;
    logic [PAIRS-1:0]   best_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [CODE_W-1:0]  canon_reg;
    logic               sort_hit;
    logic               x_match;
    logic [Q_W-1:0]     cur_idx;

    // Vertex count register; the count read from it is clamped to the supported maximum.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= VCOUNT_RESET;
        end
        else if (cfg_we)
        begin
            cfg_reg <= cfg_wdata;
        end
    end

    assign n = (int'(cfg_reg) > MAXV) ? N_W'(MAXV) : N_W'(cfg_reg);

    // Number of code bits that carry adjacency for n vertices.
    assign npairs = Q_W'((int'(n) * (int'(n) - 1)) / 2);

    assign cur_idx  = Q_W'(pair_idx(int'(pi_reg), int'(pj_reg)));
    assign sort_hit = (int'(sv_reg) < int'(n)) && (deg_reg[sv_reg] == sd_reg);

    // Status toward the controller.
    always_comb
    begin
        stat.pair_none = (int'(n) < 2);
        stat.pair_last = (int'(pi_reg) + 2 == int'(n)) && (int'(pj_reg) + 1 == int'(n));
        stat.sort_last = (sd_reg == V_W'(MAXV - 1)) && (sv_reg == V_W'(MAXV - 1));
        stat.perm_last = ~|asc;
    end

    // Re-encode the graph under the current ordering.
    always_comb
    begin
        x_next = '0;
        for (int i = 0; i < MAXV; i++)
        begin
            for (int j = i + 1; j < MAXV; j++)
            begin
                x_next[pair_idx(i, j)] = (j < int'(n)) && adj_reg[cur_reg[i]][cur_reg[j]];
            end
        end
    end

    // Next ordering: next lexicographic permutation of the last group that has
    // an ascent, later groups reset to their sorted order.
    always_comb
    begin
        int k;
        int e;
        int jj;
        int src;
        asc = '0;
        for (int p = 0; p < MAXV - 1; p++)
        begin
            asc[p] = same_reg[p] && (cur_reg[p] < cur_reg[p + 1]);
        end
        k = 0;
        for (int p = 0; p < MAXV; p++)
        begin
            if (asc[p])
            begin
                k = p;
            end
        end
        e = MAXV - 1;
        for (int p = MAXV - 2; p >= 0; p--)
        begin
            if (p > k && !same_reg[p])
            begin
                e = p;
            end
        end
        jj = k;
        for (int p = 0; p < MAXV; p++)
        begin
            if (p > k && p <= e && cur_reg[p] > cur_reg[k])
            begin
                jj = p;
            end
        end
        for (int p = 0; p < MAXV; p++)
        begin
            src = k + 1 + e - p;
            if (p < k)
            begin
                cur_next[p] = cur_reg[p];
            end
            else if (p == k)
            begin
                cur_next[p] = cur_reg[jj];
            end
            else if (p <= e)
            begin
                cur_next[p] = (src == jj) ? cur_reg[k] : cur_reg[V_W'(src)];
            end
            else
            begin
                cur_next[p] = base_reg[p];
            end
        end
    end

    assign x_match = (x_reg == code_fx_reg) && !high_reg;

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xv_reg <= 1'b0;
        end
        else
        begin
            xv_reg <= cmd.search_step;
        end
    end

    // Working registers for all phases.
    always_ff @(posedge clk)
    begin
        // Pair walker shared by load and pack.
        if (cmd.load_init || cmd.pack_init)
        begin
            pi_reg <= '0;
            pj_reg <= V_W'(1);
            q_reg  <= '0;
        end
        else if (cmd.load_step || cmd.pack_step)
        begin
            if (int'(pj_reg) + 1 == int'(n))
            begin
                pi_reg <= pi_reg + V_W'(1);
                pj_reg <= pi_reg + V_W'(2);
            end
            else
            begin
                pj_reg <= pj_reg + V_W'(1);
            end
            q_reg <= q_reg + Q_W'(1);
        end

        // Decode the input code into adjacency, degrees and fixed layout.
        if (cmd.load_init)
        begin
            code_reg    <= graph_code;
            code_fx_reg <= '0;
            for (int v = 0; v < MAXV; v++)
            begin
                adj_reg[v] <= '0;
                deg_reg[v] <= '0;
            end
        end
        else if (cmd.load_step && (int'(q_reg) < CODE_W) && code_reg[q_reg])
        begin
            adj_reg[pi_reg][pj_reg] <= 1'b1;
            adj_reg[pj_reg][pi_reg] <= 1'b1;
            deg_reg[pi_reg]         <= deg_reg[pi_reg] + V_W'(1);
            deg_reg[pj_reg]         <= deg_reg[pj_reg] + V_W'(1);
            for (int b = 0; b < PAIRS; b++)
            begin
                if (b == int'(cur_idx))
                begin
                    code_fx_reg[b] <= 1'b1;
                end
            end
        end

        // Stable sort of vertices by degree, one vertex test per cycle.
        if (cmd.sort_init)
        begin
            sd_reg    <= '0;
            sv_reg    <= '0;
            sp_reg    <= '0;
            slast_reg <= '0;
            same_reg  <= '0;
            high_reg  <= (code_reg >> npairs) != '0;
            for (int p = 0; p < MAXV; p++)
            begin
                cur_reg[p]  <= '0;
                base_reg[p] <= '0;
            end
        end
        else if (cmd.sort_step)
        begin
            if (sort_hit)
            begin
                for (int p = 0; p < MAXV; p++)
                begin
                    if (p == int'(sp_reg))
                    begin
                        cur_reg[p]  <= sv_reg;
                        base_reg[p] <= sv_reg;
                    end
                    if (p + 1 == int'(sp_reg))
                    begin
                        same_reg[p] <= (slast_reg == sd_reg);
                    end
                end
                sp_reg    <= sp_reg + V_W'(1);
                slast_reg <= sd_reg;
            end
            if (sv_reg == V_W'(MAXV - 1))
            begin
                sv_reg <= '0;
                sd_reg <= sd_reg + V_W'(1);
            end
            else
            begin
                sv_reg <= sv_reg + V_W'(1);
            end
        end
        else if (cmd.search_step)
        begin
            for (int p = 0; p < MAXV; p++)
            begin
                cur_reg[p] <= cur_next[p];
            end
        end

        // Encoded word pipeline stage.
        if (cmd.search_step)
        begin
            x_reg <= x_next;
        end

        // Minimum and match count.
        if (cmd.search_init)
        begin
            best_reg  <= '1;
            count_reg <= '0;
        end
        else if (xv_reg)
        begin
            if (x_reg < best_reg)
            begin
                best_reg <= x_reg;
            end
            if (x_match && (count_reg != '1))
            begin
                count_reg <= count_reg + COUNT_W'(1);
            end
        end

        // Compact the fixed-layout minimum back to row-major order for n.
        if (cmd.pack_init)
        begin
            canon_reg <= '0;
        end
        else if (cmd.pack_step)
        begin
            for (int b = 0; b < CODE_W; b++)
            begin
                if (b == int'(q_reg))
                begin
                    canon_reg[b] <= best_reg[cur_idx];
                end
            end
        end
    end

    assign canonical_code = canon_reg;
    assign match_count    = count_reg;

endmodule

// File: src/graph_canonical_code_search_core.sv
// Graph canonical code search core: top level joining controller and datapath.
// Depends on gccs_pkg, gccs_ctrl and gccs_datapath.
//
// Pulse start with graph_code while busy is low; the core then runs alone and
// presents canonical_code and match_count for one cycle with done high. The
// receiver cannot stall, so the word must be captured on that cycle. An item
// walks the P = n*(n-1)/2 vertex pairs once to decode and once to pack the
// result, sorts by degree and steps through the G degree-respecting
// orderings, G being the product of the factorials of the degree group
// sizes: the permutation stepper tries one ordering per cycle, so G dominates
// (up to 362880 for nine vertices of equal degree). vertex_count must be
// written via cfg_we/cfg_wdata only while idle; the core does not enforce it.
module graph_canonical_code_search_core
    import gccs_pkg::*;
#(
    parameter int MAXV = 9
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic [CODE_W-1:0]  graph_code,
    output logic               done,
    output logic [CODE_W-1:0]  canonical_code,
    output logic [COUNT_W-1:0] match_count
);

    cmd_t  cmd;
    stat_t stat;

    // Phase sequencer.
    gccs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Search datapath.
    gccs_datapath #(
        .MAXV (MAXV)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .graph_code     (graph_code),
        .cmd            (cmd),
        .stat           (stat),
        .canonical_code (canonical_code),
        .match_count    (match_count)
    );

endmodule
